// ----- hdl/quoted_string_unescaper_core_assert.svh -----
// Assertion macros shared by the RTL.
`ifndef QUOTED_STRING_UNESCAPER_CORE_ASSERT_SVH
`define QUOTED_STRING_UNESCAPER_CORE_ASSERT_SVH

// Clocked check, disabled while reset is held.
`define QSU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Clocked check that also runs during reset.
`define QSU_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`endif

// ----- hdl/qsu_pkg.sv -----
package qsu_pkg;

    typedef struct packed {
        logic [7:0] ch;
        logic       is_final;
    } t_in_word;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_mark;
        logic       failed;
    } t_out_word;

    localparam int NIBBLE_W = 4;
    localparam int DIGIT_W  = 6;

    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_X       = 8'h78;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_T       = 8'h74;
    localparam logic [7:0] CH_R       = 8'h72;
    localparam logic [7:0] CH_N       = 8'h6E;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;

    localparam logic [7:0] BYTE_TAB = 8'h09;
    localparam logic [7:0] BYTE_CR  = 8'h0D;
    localparam logic [7:0] BYTE_LF  = 8'h0A;

    localparam logic [7:0] NUM_DEC   = 8'd10;
    localparam logic [7:0] NUM_ALPHA = 8'd26;

endpackage

// ----- hdl/quoted_string_unescaper_core.sv -----
// Channel | Handshake                    | Word
// --------+------------------------------+---------------------------------
// input   | i_in_valid / o_in_ready      | i_in_word  (ch, is_final)
// output  | o_out_valid / i_out_ready    | o_out_word (data_byte, has_byte,
//         |                              |             end_mark, failed)
//
// One byte accepted per cycle while the output is not stalled; a result passes
// through the input register and then the output register. The decode between
// them is combinational and carries the phase / nibble / error state.
// Reset (i_rst_n low, synchronous) empties both registers and returns the
// decoder to waiting for an opening quote.
// A stalled output holds its word and the decode stage with it; once the
// input register is full, o_in_ready drops until the word is taken.
`include "quoted_string_unescaper_core_assert.svh"

module quoted_string_unescaper_core
    import qsu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    typedef enum logic [2:0] {
        PH_OPEN = 3'd0,
        PH_BODY = 3'd1,
        PH_ESC  = 3'd2,
        PH_HEX1 = 3'd3,
        PH_HEX2 = 3'd4
    } t_phase;

    t_phase                r_phase, n_phase;
    logic [NIBBLE_W-1:0]   r_hi, n_hi;
    logic                  r_err, n_err;

    logic                  r_in_valid;
    t_in_word              r_in_word;
    logic                  r_out_valid;
    t_out_word             r_out_word;

    logic                  s1_go;
    logic                  res_valid;
    t_out_word             res_word;

    logic [7:0]            off_num;
    logic [7:0]            off_alpha;
    logic                  is_num;
    logic                  is_alpha;
    logic                  dig_ok;
    logic [DIGIT_W-1:0]    dig_val;

    assign s1_go       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || s1_go;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // digit 0-9 -> 0..9, A-Z -> 10..35
    always_comb begin
        off_num   = r_in_word.ch - CH_ZERO;
        off_alpha = r_in_word.ch - CH_UPPER_A;
        is_num    = (r_in_word.ch >= CH_ZERO) && (off_num < NUM_DEC);
        is_alpha  = (r_in_word.ch >= CH_UPPER_A) && (off_alpha < NUM_ALPHA);
        dig_ok    = is_num || is_alpha;
        if (is_num) begin
            dig_val = off_num[DIGIT_W-1:0];
        end else begin
            dig_val = DIGIT_W'(off_alpha + NUM_DEC);
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_hi      = r_hi;
        n_err     = r_err;
        res_valid = 1'b0;
        res_word  = '0;
        if (r_in_word.is_final) begin
            res_valid         = 1'b1;
            res_word.end_mark = 1'b1;
            res_word.failed   = r_err || (r_phase == PH_ESC) ||
                                (r_phase == PH_HEX1) || (r_phase == PH_HEX2);
            n_phase = PH_OPEN;
            n_hi    = '0;
            n_err   = 1'b0;
        end else if (r_phase == PH_OPEN) begin
            n_phase = PH_BODY;
        end else if (!r_err) begin
            unique case (r_phase)
                PH_ESC: begin
                    n_phase = PH_BODY;
                    unique case (r_in_word.ch)
                        CH_T: begin
                            res_valid          = 1'b1;
                            res_word.has_byte  = 1'b1;
                            res_word.data_byte = BYTE_TAB;
                        end
                        CH_R: begin
                            res_valid          = 1'b1;
                            res_word.has_byte  = 1'b1;
                            res_word.data_byte = BYTE_CR;
                        end
                        CH_N: begin
                            res_valid          = 1'b1;
                            res_word.has_byte  = 1'b1;
                            res_word.data_byte = BYTE_LF;
                        end
                        CH_BSLASH, CH_DQUOTE, CH_SQUOTE: begin
                            res_valid          = 1'b1;
                            res_word.has_byte  = 1'b1;
                            res_word.data_byte = r_in_word.ch;
                        end
                        CH_X: begin
                            n_phase = PH_HEX1;
                        end
                        CH_DOT: begin
                            n_phase = PH_BODY;
                        end
                        default: begin
                            n_err = 1'b1;
                        end
                    endcase
                end
                PH_HEX1: begin
                    if (dig_ok) begin
                        n_hi    = dig_val[NIBBLE_W-1:0];
                        n_phase = PH_HEX2;
                    end else begin
                        n_err   = 1'b1;
                        n_phase = PH_BODY;
                    end
                end
                PH_HEX2: begin
                    n_phase = PH_BODY;
                    if (dig_ok) begin
                        // digit may exceed 15; its upper bits OR into the high nibble
                        res_valid          = 1'b1;
                        res_word.has_byte  = 1'b1;
                        res_word.data_byte = {r_hi, {NIBBLE_W{1'b0}}} |
                                             {2'b00, dig_val};
                        n_hi               = '0;
                    end else begin
                        n_err = 1'b1;
                    end
                end
                default: begin
                    if (r_in_word.ch == CH_BSLASH) begin
                        n_phase = PH_ESC;
                    end else begin
                        n_phase            = PH_BODY;
                        res_valid          = 1'b1;
                        res_word.has_byte  = 1'b1;
                        res_word.data_byte = r_in_word.ch;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_OPEN;
            r_hi        <= '0;
            r_err       <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (s1_go) begin
                r_phase     <= n_phase;
                r_hi        <= n_hi;
                r_err       <= n_err;
                r_out_valid <= res_valid;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_word <= i_in_word;
        end
        if (s1_go && res_valid) begin
            r_out_word <= res_word;
        end
    end

    `QSU_ASSERT(a_failed_only_on_end,
        (o_out_valid && o_out_word.failed) |-> o_out_word.end_mark,
        "failed flag on a non-end word")
    `QSU_ASSERT(a_end_restarts,
        (s1_go && r_in_word.is_final) |=> (r_phase == PH_OPEN && !r_err),
        "state not cleared after closing quote")
    `QSU_ASSERT(a_err_sticky,
        (r_err && !(s1_go && r_in_word.is_final)) |=> r_err,
        "error flag dropped inside a string")
    `QSU_ASSERT_ALWAYS(a_no_byte_on_end,
        o_out_valid |-> !(o_out_word.has_byte && o_out_word.end_mark),
        "end word carries a data byte")

endmodule

// ----- verif/tb_quoted_string_unescaper_core.sv -----
`timescale 1ns / 100ps

module tb_quoted_string_unescaper_core;
    import qsu_pkg::*;

    localparam int TOTAL_WORDS  = 1350;
    localparam int HOLD_CYCLES  = 200;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;

    localparam logic [7:0] SIMPLE_ESC [7] = '{CH_T, CH_R, CH_N, CH_BSLASH,
                                              CH_DQUOTE, CH_SQUOTE, CH_DOT};

    typedef enum logic [2:0] {
        ST_QUOTE,
        ST_TEXT,
        ST_ESCAPE,
        ST_HEX_HI,
        ST_HEX_LO
    } decode_state_e;

    typedef enum int {
        TRAFFIC_RECV_SLOW,
        TRAFFIC_SEND_SLOW,
        TRAFFIC_FULL
    } traffic_e;

    class unescape_checker;
        t_out_word     decoded_q[$];
        decode_state_e state;
        logic [3:0]    hi_nibble;
        logic          err_flag;
        int            errors;

        function new();
            clear_string();
            errors = 0;
        endfunction

        function void clear_string();
            state     = ST_QUOTE;
            hi_nibble = 4'h0;
            err_flag  = 1'b0;
        endfunction

        // 0..35 for 0-9 / A-Z, -1 otherwise
        static function int digit_value(logic [7:0] c);
            if (c >= CH_ZERO && c < CH_ZERO + NUM_DEC) begin
                return int'(c - CH_ZERO);
            end
            if (c >= CH_UPPER_A && c < CH_UPPER_A + NUM_ALPHA) begin
                return int'(c - CH_UPPER_A) + 10;
            end
            return -1;
        endfunction

        function void emit_byte(logic [7:0] b);
            t_out_word r;
            r           = '0;
            r.data_byte = b;
            r.has_byte  = 1'b1;
            decoded_q.push_back(r);
        endfunction

        function void take_byte(t_in_word w);
            t_out_word r;
            int        d;
            if (w.is_final) begin
                r          = '0;
                r.end_mark = 1'b1;
                r.failed   = err_flag || (state inside {ST_ESCAPE, ST_HEX_HI, ST_HEX_LO});
                decoded_q.push_back(r);
                clear_string();
                return;
            end
            if (state == ST_QUOTE) begin
                state = ST_TEXT;
                return;
            end
            // sticky error: drop everything until the closing quote
            if (err_flag) begin
                return;
            end
            case (state)
                ST_ESCAPE: begin
                    state = ST_TEXT;
                    case (w.ch)
                        CH_T:      emit_byte(BYTE_TAB);
                        CH_R:      emit_byte(BYTE_CR);
                        CH_N:      emit_byte(BYTE_LF);
                        CH_BSLASH: emit_byte(CH_BSLASH);
                        CH_DQUOTE: emit_byte(CH_DQUOTE);
                        CH_SQUOTE: emit_byte(CH_SQUOTE);
                        CH_X:      state = ST_HEX_HI;
                        CH_DOT:    ;
                        default:   err_flag = 1'b1;
                    endcase
                end
                ST_HEX_HI: begin
                    d = digit_value(w.ch);
                    if (d < 0) begin
                        err_flag = 1'b1;
                        state    = ST_TEXT;
                    end else begin
                        hi_nibble = 4'(d);
                        state     = ST_HEX_LO;
                    end
                end
                ST_HEX_LO: begin
                    d     = digit_value(w.ch);
                    state = ST_TEXT;
                    if (d < 0) begin
                        err_flag = 1'b1;
                    end else begin
                        // digits above 15 spill into the high nibble
                        emit_byte({hi_nibble, 4'h0} | 8'(d));
                        hi_nibble = 4'h0;
                    end
                end
                default: begin
                    state = ST_TEXT;
                    if (w.ch == CH_BSLASH) begin
                        state = ST_ESCAPE;
                    end else begin
                        emit_byte(w.ch);
                    end
                end
            endcase
        endfunction

        function void check_word(t_out_word got);
            t_out_word want;
            if (decoded_q.size() == 0) begin
                $error("unexpected result word %h", got);
                errors++;
                return;
            end
            want = decoded_q.pop_front();
            if (got.data_byte !== want.data_byte) begin
                $error("data_byte: expected %h, got %h", want.data_byte, got.data_byte);
                errors++;
            end
            if (got.has_byte !== want.has_byte) begin
                $error("has_byte: expected %b, got %b", want.has_byte, got.has_byte);
                errors++;
            end
            if (got.end_mark !== want.end_mark) begin
                $error("end_mark: expected %b, got %b", want.end_mark, got.end_mark);
                errors++;
            end
            if (got.failed !== want.failed) begin
                $error("failed: expected %b, got %b", want.failed, got.failed);
                errors++;
            end
        endfunction

        function int pending();
            return decoded_q.size();
        endfunction
    endclass

    logic      i_clk    = 1'b0;
    logic      i_rst_n  = 1'b0;
    logic      in_valid = 1'b0;
    t_in_word  in_word  = '0;
    logic      out_ready = 1'b0;
    logic      in_ready;
    logic      out_valid;
    t_out_word out_word;

    unescape_checker decode_chk = new();
    traffic_e        traffic_mode = TRAFFIC_RECV_SLOW;
    int              sent_count = 0;
    int              stall_cycles = 0;

    always #5 i_clk = ~i_clk;

    quoted_string_unescaper_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_word  (in_word),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_word (out_word)
    );

    // ends the run if no word moves on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic t_in_word byte_word(input logic [7:0] c, input logic fin);
        t_in_word w;
        w.ch       = c;
        w.is_final = fin;
        return w;
    endfunction

    function automatic logic [7:0] rand_digit();
        int idx;
        idx = $urandom_range(35);
        return (idx < 10) ? CH_ZERO + 8'(idx) : CH_UPPER_A + 8'(idx - 10);
    endfunction

    function automatic logic [7:0] rand_non_digit();
        logic [7:0] b;
        case ($urandom_range(4))
            0: b = CH_ZERO - 8'd1;
            1: b = CH_ZERO + NUM_DEC;
            2: b = CH_UPPER_A - 8'd1;
            3: b = CH_UPPER_A + NUM_ALPHA;
            default: begin
                do b = 8'($urandom_range(255));
                while (unescape_checker::digit_value(b) >= 0);
            end
        endcase
        return b;
    endfunction

    // valid stays up across back-to-back words; dropped only for an idle gap
    task automatic send_word(input t_in_word w);
        int idle_pct;
        idle_pct = (traffic_mode == TRAFFIC_RECV_SLOW) ? 23 :
                   (traffic_mode == TRAFFIC_SEND_SLOW) ? 83 : 0;
        if ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < idle_pct) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        decode_chk.take_byte(w);
        sent_count++;
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++) begin
            send_word(byte_word(txt[i], 1'b0));
        end
    endtask

    task automatic send_quoted_string();
        t_in_word   s[$];
        int         body_len;
        int         pick;
        logic [7:0] b;
        s.push_back(byte_word(8'($urandom_range(255)), $urandom_range(15) == 0));
        if (!s[0].is_final) begin
            body_len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(10);
            repeat (body_len) begin
                pick = $urandom_range(99);
                if (pick < 45) begin
                    do b = 8'($urandom_range(255)); while (b == CH_BSLASH);
                    s.push_back(byte_word(b, 1'b0));
                end else if (pick < 70) begin
                    s.push_back(byte_word(CH_BSLASH, 1'b0));
                    s.push_back(byte_word(SIMPLE_ESC[$urandom_range(6)], 1'b0));
                end else if (pick < 94) begin
                    // hex escape; a slice of these carry a bad first or second digit
                    s.push_back(byte_word(CH_BSLASH, 1'b0));
                    s.push_back(byte_word(CH_X, 1'b0));
                    s.push_back(byte_word((pick >= 85 && pick < 90) ?
                                          rand_non_digit() : rand_digit(), 1'b0));
                    s.push_back(byte_word((pick >= 90) ? rand_non_digit() : rand_digit(), 1'b0));
                end else if (pick < 97) begin
                    do b = 8'($urandom_range(255));
                    while (b inside {CH_T, CH_R, CH_N, CH_BSLASH, CH_DQUOTE,
                                     CH_SQUOTE, CH_X, CH_DOT});
                    s.push_back(byte_word(CH_BSLASH, 1'b0));
                    s.push_back(byte_word(b, 1'b0));
                end else begin
                    s.push_back(byte_word(8'($urandom_range(255)), 1'b0));
                end
            end
            // now and then the string ends inside an escape
            case ($urandom_range(15))
                0: s.push_back(byte_word(CH_BSLASH, 1'b0));
                1: begin
                    s.push_back(byte_word(CH_BSLASH, 1'b0));
                    s.push_back(byte_word(CH_X, 1'b0));
                end
                2: begin
                    s.push_back(byte_word(CH_BSLASH, 1'b0));
                    s.push_back(byte_word(CH_X, 1'b0));
                    s.push_back(byte_word(rand_digit(), 1'b0));
                end
                default: ;
            endcase
            s.push_back(byte_word(($urandom_range(3) == 0) ?
                                  8'($urandom_range(255)) : CH_DQUOTE, 1'b1));
        end
        foreach (s[i]) begin
            send_word(s[i]);
        end
    endtask

    task automatic take_results();
        bit held;
        int hold_left;
        int idle_pct;
        held      = 1'b0;
        hold_left = 0;
        forever begin
            if (!held && traffic_mode == TRAFFIC_FULL && sent_count >= 1000) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            idle_pct = (traffic_mode == TRAFFIC_RECV_SLOW) ? 83 :
                       (traffic_mode == TRAFFIC_SEND_SLOW) ? 23 : 0;
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else begin
                out_ready <= ($urandom_range(99) >= idle_pct);
            end
            @(posedge i_clk);
            if (out_valid && out_ready) begin
                decode_chk.check_word(out_word);
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        fork
            take_results();
        join_none

        // empty string: final flag on the opening byte
        send_word(byte_word(8'hFF, 1'b1));
        // every escape, byte extremes, hex digit above 15
        send_word(byte_word(8'h00, 1'b0));
        send_word(byte_word(8'hFF, 1'b0));
        send_text("\\t\\r\\n\\\\\\\"\\'\\.\\xZ9");
        send_word(byte_word(CH_DQUOTE, 1'b1));
        // string ends between the two hex digits
        send_word(byte_word(CH_DQUOTE, 1'b0));
        send_text("\\xA");
        send_word(byte_word(CH_DQUOTE, 1'b1));

        while (sent_count < TOTAL_WORDS) begin
            traffic_mode = (sent_count < 450) ? TRAFFIC_RECV_SLOW :
                           (sent_count < 900) ? TRAFFIC_SEND_SLOW : TRAFFIC_FULL;
            send_quoted_string();
        end
        in_valid <= 1'b0;

        while (decode_chk.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (decode_chk.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/qsu_pkg.sv
hdl/quoted_string_unescaper_core.sv
verif/tb_quoted_string_unescaper_core.sv
